// ===== rtl/lkvt_pkg.sv =====
package lkvt_pkg;

  localparam int FieldBits = 32;
  localparam int CountFieldBits = 5;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [FieldBits-1:0] key;
    logic [FieldBits-1:0] value;
  } lkvt_in_t;

  typedef struct packed {
    status_e                   status;
    logic [FieldBits-1:0]      read_value;
    logic [CountFieldBits-1:0] entry_count;
  } lkvt_out_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic execute;
  } lkvt_cmd_t;

endpackage

// ===== rtl/lkvt_ctrl.sv =====
module lkvt_ctrl import lkvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lkvt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_ACT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = accept;
  assign cmd_o.compare = (state_q == ST_CMP);
  assign cmd_o.execute = (state_q == ST_ACT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_ACT;
      end
      ST_ACT: begin
        if (cmd_o.execute) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_exec_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_q)
    else $error("Executed operation did not produce an output beat.");

  a_accept_to_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CMP))
    else $error("Accepted beat was not followed by the compare step.");

endmodule

// ===== rtl/lkvt_datapath.sv =====
module lkvt_datapath import lkvt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lkvt_cmd_t cmd_i,
  input  lkvt_in_t  in_item_i,
  output lkvt_out_t out_item_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  kind_e                 kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CntW-1:0]       count_q, count_d;
  logic [KEY_BITS-1:0]   keys_q [CAPACITY];
  logic [VALUE_BITS-1:0] vals_q [CAPACITY];
  logic [CAPACITY-1:0]   hit_q, hit_d;
  lkvt_out_t             out_q, out_d;

  logic [KEY_BITS+FieldBits-1:0]   key_ext;
  logic [VALUE_BITS+FieldBits-1:0] val_ext;
  logic [FieldBits+VALUE_BITS-1:0] rd_ext;
  logic [CountFieldBits+CntW-1:0]  cnt_ext;
  logic [CAPACITY-1:0]             low_mask;
  logic [CAPACITY-1:0]             first;
  logic [CAPACITY-1:0]             shift;
  logic                            found;
  logic                            full;
  logic                            do_append;
  logic                            do_remove;
  logic [VALUE_BITS-1:0]           rd_val;

  assign key_ext = {{KEY_BITS{1'b0}}, in_item_i.key};
  assign val_ext = {{VALUE_BITS{1'b0}}, in_item_i.value};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_item_i.kind;
      key_q  <= key_ext[KEY_BITS-1:0];
      val_q  <= val_ext[VALUE_BITS-1:0];
    end
    if (cmd_i.compare) begin
      hit_q <= hit_d;
    end
    if (cmd_i.execute) begin
      out_q <= out_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    localparam logic [CntW-1:0] Idx = CntW'(i);
    assign hit_d[i] = (Idx < count_q) && (keys_q[i] == key_q);
  end

  // Isolating the lowest set hit bit picks the oldest matching entry.
  assign low_mask = hit_q ^ (hit_q - CAPACITY'(1));
  assign first    = hit_q & low_mask;
  assign shift    = ~low_mask | first;
  assign found    = |hit_q;
  assign full     = (count_q >= CntW'(CAPACITY));

  assign do_append = cmd_i.execute && (kind_q == KIND_APPEND) && !full;
  assign do_remove = cmd_i.execute && (kind_q == KIND_REMOVE) && found;

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | (vals_q[i] & {VALUE_BITS{first[i]}});
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    if (i + 1 < CAPACITY) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (do_append && (count_q == Idx)) begin
          keys_q[i] <= key_q;
          vals_q[i] <= val_q;
        end else if (do_remove && shift[i]) begin
          keys_q[i] <= keys_q[i+1];
          vals_q[i] <= vals_q[i+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (do_append && (count_q == Idx)) begin
          keys_q[i] <= key_q;
          vals_q[i] <= val_q;
        end
      end
    end
  end

  always_comb begin
    count_d        = count_q;
    out_d.status   = STATUS_OK;
    rd_ext         = '0;
    case (kind_q)
      KIND_APPEND: begin
        if (full) begin
          out_d.status = STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      KIND_LOOKUP: begin
        if (found) begin
          rd_ext = {{FieldBits{1'b0}}, rd_val};
        end else begin
          out_d.status = STATUS_MISS;
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          count_d = count_q - CntW'(1);
        end else begin
          out_d.status = STATUS_MISS;
        end
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    cnt_ext           = {{CountFieldBits{1'b0}}, count_d};
    out_d.read_value  = rd_ext[FieldBits-1:0];
    out_d.entry_count = cnt_ext[CountFieldBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  assign out_item_o = out_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("Entry count exceeds the table capacity.");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_append |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("Accepted append did not grow the table by one entry.");

endmodule

// ===== rtl/linear_key_value_table_unit.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_i   (kind, key, value)
// out      output     out_valid_o / out_stall_i out_item_o (status, read_value, entry_count)
//
// Each operation runs in three steps: capture, a parallel key compare across all
// entries into a hit register, then the table update and result load.
// A new beat is taken once the update has been done, so one operation is in work at a time.
// A result waits in the output register, and a stalled output holds only the update step.
// Reset clears the entry count and the control state; entry contents are left as they are.
module linear_key_value_table_unit import lkvt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lkvt_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lkvt_out_t out_item_o
);

  lkvt_cmd_t cmd;

  lkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  lkvt_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

endmodule
